### src/assert_macros.svh
// Assertion helpers for the RTL files, used by the sequencer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cond holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/mdms_pkg.sv
// ----------------------------------------------------------------------------
// mdms_pkg
// Types, codes and reset values shared by the drive mode sequencer files.
// ----------------------------------------------------------------------------
package mdms_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STOP_THR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HALT_THR = 1'b1;

    localparam logic [14:0] STOP_THR_RESET = 15'd100;
    localparam logic [14:0] HALT_THR_RESET = 15'd200;

    // Sequencer states
    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_START  = 3'd1;
    localparam logic [2:0] ST_TORQUE = 3'd2;
    localparam logic [2:0] ST_SPEED  = 3'd3;
    localparam logic [2:0] ST_DIRCHG = 3'd4;

    // Drive modes
    localparam logic [1:0] MD_BLOCKED      = 2'd0;
    localparam logic [1:0] MD_ZERO_CURRENT = 2'd1;
    localparam logic [1:0] MD_SPEED        = 2'd2;
    localparam logic [1:0] MD_TORQUE       = 2'd3;

    typedef struct packed {
        logic [14:0] stop_thr;
        logic [14:0] halt_thr;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] measured_speed;
        logic               direction_request;
        logic [10:0]        torque_demand;
        logic               auto_enable;
        logic [14:0]        speed_setpoint;
        logic signed [15:0] ramped_current;
        logic signed [15:0] speed_loop_output;
    } tick_t;

    typedef struct packed {
        logic [2:0]         sequencer_state;
        logic [1:0]         drive_mode;
        logic signed [15:0] current_reference;
        logic [10:0]        current_ramp_target;
        logic [14:0]        speed_ramp_target;
        logic               speed_ramp_clear;
        logic               applied_direction;
    } result_t;

    typedef struct packed {
        logic [2:0]  state;
        logic [1:0]  mode;
        logic        direction;
        logic [15:0] current_ref;
        logic [10:0] current_target;
        logic [14:0] speed_target;
    } seq_regs_t;

endpackage

### src/mdms_if.sv
// ----------------------------------------------------------------------------
// mdms_tick_if / mdms_result_if
// Valid/ready channels for control ticks and sequencer results.
// ----------------------------------------------------------------------------
interface mdms_tick_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] measured_speed;
    logic               direction_request;
    logic [10:0]        torque_demand;
    logic               auto_enable;
    logic [14:0]        speed_setpoint;
    logic signed [15:0] ramped_current;
    logic signed [15:0] speed_loop_output;

    modport source (
        output valid, measured_speed, direction_request, torque_demand,
               auto_enable, speed_setpoint, ramped_current, speed_loop_output,
        input  ready
    );
    modport sink (
        input  valid, measured_speed, direction_request, torque_demand,
               auto_enable, speed_setpoint, ramped_current, speed_loop_output,
        output ready
    );
endinterface

interface mdms_result_if;
    logic               valid;
    logic               ready;
    logic [2:0]         sequencer_state;
    logic [1:0]         drive_mode;
    logic signed [15:0] current_reference;
    logic [10:0]        current_ramp_target;
    logic [14:0]        speed_ramp_target;
    logic               speed_ramp_clear;
    logic               applied_direction;

    modport source (
        output valid, sequencer_state, drive_mode, current_reference,
               current_ramp_target, speed_ramp_target, speed_ramp_clear,
               applied_direction,
        input  ready
    );
    modport sink (
        input  valid, sequencer_state, drive_mode, current_reference,
               current_ramp_target, speed_ramp_target, speed_ramp_clear,
               applied_direction,
        output ready
    );
endinterface

### src/mdms_cfg_regs.sv
// ----------------------------------------------------------------------------
// mdms_cfg_regs
// Speed threshold registers written through the plain configuration port.
// ----------------------------------------------------------------------------
module mdms_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mdms_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mdms_pkg::CFG_DATA_W-1:0]  cfg_data,
    output mdms_pkg::cfg_t                   cfg
);
    import mdms_pkg::*;

    cfg_t cfg_reg;

    // Load the addressed threshold
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stop_thr <= STOP_THR_RESET;
            cfg_reg.halt_thr <= HALT_THR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_STOP_THR: cfg_reg.stop_thr <= cfg_data;
                REG_HALT_THR: cfg_reg.halt_thr <= cfg_data;
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### src/mdms_step.sv
// ----------------------------------------------------------------------------
// mdms_step
// One control tick: sequencer transition, then current reference selection.
// ----------------------------------------------------------------------------
module mdms_step (
    input  mdms_pkg::cfg_t     cfg,
    input  mdms_pkg::tick_t    tick,
    input  mdms_pkg::seq_regs_t cur,
    output mdms_pkg::seq_regs_t nxt,
    output mdms_pkg::result_t  res
);
    import mdms_pkg::*;

    logic [15:0] speed_bits;
    logic [15:0] mag;
    logic        stopped;
    logic        halted;
    logic        dir_differs;
    logic        clear;
    seq_regs_t   upd;

    // Speed magnitude; the most negative code maps to 32768
    assign speed_bits  = tick.measured_speed;
    assign mag         = speed_bits[15] ? (~speed_bits + 16'd1) : speed_bits;
    assign stopped     = mag < {1'b0, cfg.stop_thr};
    assign halted      = mag < {1'b0, cfg.halt_thr};
    assign dir_differs = tick.direction_request != cur.direction;

    // Sequencer transition
    always_comb
    begin
        upd   = cur;
        clear = 1'b0;
        unique case (cur.state)
            ST_INIT:
            begin
                upd.state = ST_START;
            end
            ST_START:
            begin
                if (stopped)
                    upd.mode = MD_BLOCKED;
                if (dir_differs)
                begin
                    upd.state = ST_DIRCHG;
                    upd.mode  = MD_ZERO_CURRENT;
                end
                else if (tick.torque_demand != 11'd0)
                begin
                    upd.state = ST_TORQUE;
                    upd.mode  = MD_TORQUE;
                end
                else if (tick.auto_enable && tick.speed_setpoint != 15'd0)
                begin
                    upd.state        = ST_SPEED;
                    upd.mode         = MD_SPEED;
                    upd.speed_target = 15'd0;
                    clear            = 1'b1;
                end
            end
            ST_TORQUE:
            begin
                if (cur.current_ref == 16'd0 && halted)
                begin
                    upd.state = ST_START;
                    upd.mode  = MD_BLOCKED;
                end
                else if (dir_differs)
                begin
                    upd.state = ST_DIRCHG;
                    upd.mode  = MD_ZERO_CURRENT;
                end
            end
            ST_SPEED:
            begin
                upd.speed_target = tick.speed_setpoint;
                if (tick.speed_setpoint == 15'd0 || !tick.auto_enable)
                begin
                    upd.speed_target = 15'd0;
                    if (stopped)
                        upd.state = ST_START;
                end
                else if (tick.torque_demand != 11'd0)
                begin
                    upd.state = ST_TORQUE;
                    upd.mode  = MD_TORQUE;
                end
            end
            ST_DIRCHG:
            begin
                if (stopped)
                begin
                    upd.direction = tick.direction_request;
                    upd.state     = ST_START;
                end
            end
            default:
            begin
                upd.state = ST_INIT;
            end
        endcase
    end

    // Select the current reference from the new mode
    always_comb
    begin
        nxt = upd;
        case (upd.mode)
            MD_SPEED:
            begin
                nxt.current_ref = tick.speed_loop_output;
            end
            MD_TORQUE:
            begin
                nxt.current_target = tick.torque_demand;
                nxt.current_ref    = upd.direction ? (~tick.ramped_current + 16'sd1)
                                                   : tick.ramped_current;
            end
            default:
            begin
                nxt.current_target = 11'd0;
                nxt.current_ref    = tick.ramped_current;
            end
        endcase
    end

    // Pack the result beat
    always_comb
    begin
        res.sequencer_state     = nxt.state;
        res.drive_mode          = nxt.mode;
        res.current_reference   = nxt.current_ref;
        res.current_ramp_target = nxt.current_target;
        res.speed_ramp_target   = nxt.speed_target;
        res.speed_ramp_clear    = clear;
        res.applied_direction   = nxt.direction;
    end

endmodule

### src/motor_drive_mode_sequencer.sv
// ----------------------------------------------------------------------------
// motor_drive_mode_sequencer
// A tick beat is captured in the input register, then moves through the step
// logic into the result register.
// Throughput: one tick per cycle while the result side accepts; the state
// registers update in the same cycle a tick moves into the result register.
// Reset: asynchronous, active low; init state, blocked mode, clockwise,
// zeroed reference and targets, thresholds 100 and 200, both stages empty.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module motor_drive_mode_sequencer (
    input  logic                             clk,
    input  logic                             rst_n,
    mdms_tick_if.sink                        tick,
    mdms_result_if.source                    result,
    input  logic                             cfg_we,
    input  logic [mdms_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mdms_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import mdms_pkg::*;

    cfg_t      cfg;
    logic      tick_valid_reg;
    tick_t     tick_item_reg;
    logic      result_valid_reg;
    result_t   result_item_reg;
    seq_regs_t seq_reg;
    seq_regs_t seq_next;
    result_t   result_next;
    logic      advance;
    logic      tick_beat;

    mdms_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mdms_step u_step (
        .cfg  (cfg),
        .tick (tick_item_reg),
        .cur  (seq_reg),
        .nxt  (seq_next),
        .res  (result_next)
    );

    // Handshake: a held tick advances into a free or draining result register
    assign advance    = tick_valid_reg && (!result_valid_reg || result.ready);
    assign tick.ready = !tick_valid_reg || advance;
    assign tick_beat  = tick.valid && tick.ready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tick_valid_reg <= 1'b0;
        else if (tick.ready)
            tick_valid_reg <= tick.valid;
    end

    always_ff @(posedge clk)
    begin
        if (tick_beat)
        begin
            tick_item_reg.measured_speed    <= tick.measured_speed;
            tick_item_reg.direction_request <= tick.direction_request;
            tick_item_reg.torque_demand     <= tick.torque_demand;
            tick_item_reg.auto_enable       <= tick.auto_enable;
            tick_item_reg.speed_setpoint    <= tick.speed_setpoint;
            tick_item_reg.ramped_current    <= tick.ramped_current;
            tick_item_reg.speed_loop_output <= tick.speed_loop_output;
        end
    end

    // Sequencer state: advance once per tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg.state          <= ST_INIT;
            seq_reg.mode           <= MD_BLOCKED;
            seq_reg.direction      <= 1'b0;
            seq_reg.current_ref    <= 16'd0;
            seq_reg.current_target <= 11'd0;
            seq_reg.speed_target   <= 15'd0;
        end
        else if (advance)
        begin
            seq_reg <= seq_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (advance)
            result_valid_reg <= 1'b1;
        else if (result.ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_item_reg <= result_next;
    end

    // Drive the result channel
    assign result.valid               = result_valid_reg;
    assign result.sequencer_state     = result_item_reg.sequencer_state;
    assign result.drive_mode          = result_item_reg.drive_mode;
    assign result.current_reference   = result_item_reg.current_reference;
    assign result.current_ramp_target = result_item_reg.current_ramp_target;
    assign result.speed_ramp_target   = result_item_reg.speed_ramp_target;
    assign result.speed_ramp_clear    = result_item_reg.speed_ramp_clear;
    assign result.applied_direction   = result_item_reg.applied_direction;

    // Checks
    `ASSERT_NEXT(a_state_holds_idle, clk, rst_n, !advance, $stable(seq_reg),
                 "state moved without a tick")
    `ASSERT_IMPLIES(a_clear_in_speed, clk, rst_n,
                    result_valid_reg && result_item_reg.speed_ramp_clear,
                    result_item_reg.sequencer_state == ST_SPEED &&
                    result_item_reg.drive_mode == MD_SPEED,
                    "ramp clear outside speed run entry")
    `ASSERT_ALWAYS(a_state_legal, clk, rst_n, seq_reg.state <= ST_DIRCHG,
                   "sequencer state out of range")

endmodule

### dv/mdms_checker.sv
// ----------------------------------------------------------------------------
// mdms_checker
// Watches the tick, result and register-write ports of the drive mode
// sequencer. Predicts each result from its own copy of the sequencer state and
// thresholds, then compares every result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module mdms_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    mdms_tick_if                            tick,
    mdms_result_if                          result,
    input  logic                            cfg_we,
    input  logic [mdms_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mdms_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              mismatch_count,
    output int                              results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    import mdms_pkg::*;

    // Predicted sequencer registers and thresholds
    logic [2:0]  seq_st;
    logic [1:0]  seq_md;
    logic        seq_dir;
    logic [15:0] cur_ref;
    logic [10:0] cur_tgt;
    logic [14:0] spd_tgt;
    logic [14:0] thr_stop;
    logic [14:0] thr_halt;

    result_t due_results[$];

    assign results_due = due_results.size();

    // Run one control tick through the sequencer and the reference select
    function automatic result_t sequence_tick(input tick_t t);
        logic [16:0] mag;
        logic        stopped;
        logic        clear;
        result_t     r;
        // -32768 has magnitude 32768, never below a 15-bit threshold
        mag = t.measured_speed[15] ? 17'h10000 - {1'b0, t.measured_speed}
                                   : {1'b0, t.measured_speed};
        stopped = mag < {2'b00, thr_stop};
        clear = 1'b0;
        case (seq_st)
            ST_INIT:
                seq_st = ST_START;
            ST_START:
            begin
                if (stopped)
                    seq_md = MD_BLOCKED;
                if (t.direction_request != seq_dir)
                begin
                    seq_st = ST_DIRCHG;
                    seq_md = MD_ZERO_CURRENT;
                end
                else if (t.torque_demand != 11'd0)
                begin
                    seq_md = MD_TORQUE;
                    seq_st = ST_TORQUE;
                end
                else if (t.auto_enable && t.speed_setpoint != 15'd0)
                begin
                    seq_md = MD_SPEED;
                    spd_tgt = 15'd0;
                    clear = 1'b1;
                    seq_st = ST_SPEED;
                end
            end
            ST_TORQUE:
            begin
                if (cur_ref == 16'd0 && mag < {2'b00, thr_halt})
                begin
                    seq_md = MD_BLOCKED;
                    seq_st = ST_START;
                end
                else if (t.direction_request != seq_dir)
                begin
                    seq_st = ST_DIRCHG;
                    seq_md = MD_ZERO_CURRENT;
                end
            end
            ST_SPEED:
            begin
                spd_tgt = t.speed_setpoint;
                if (t.speed_setpoint == 15'd0 || !t.auto_enable)
                begin
                    spd_tgt = 15'd0;
                    if (stopped)
                        seq_st = ST_START;
                end
                else if (t.torque_demand != 11'd0)
                begin
                    seq_md = MD_TORQUE;
                    seq_st = ST_TORQUE;
                end
            end
            ST_DIRCHG:
            begin
                if (stopped)
                begin
                    seq_dir = t.direction_request;
                    seq_st = ST_START;
                end
            end
            default:
                seq_st = ST_INIT;
        endcase

        // Select the current reference; speed mode keeps the current target
        case (seq_md)
            MD_SPEED:
                cur_ref = t.speed_loop_output;
            MD_TORQUE:
            begin
                cur_tgt = t.torque_demand;
                cur_ref = seq_dir ? 16'd0 - t.ramped_current : t.ramped_current;
            end
            default:
            begin
                cur_tgt = 11'd0;
                cur_ref = t.ramped_current;
            end
        endcase

        r.sequencer_state     = seq_st;
        r.drive_mode          = seq_md;
        r.current_reference   = cur_ref;
        r.current_ramp_target = cur_tgt;
        r.speed_ramp_target   = spd_tgt;
        r.speed_ramp_clear    = clear;
        r.applied_direction   = seq_dir;
        return r;
    endfunction

    // Track register writes, predict on tick beats, compare on result beats
    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        tick_t   t;
        if (!rst_n)
        begin
            seq_st   = ST_INIT;
            seq_md   = MD_BLOCKED;
            seq_dir  = 1'b0;
            cur_ref  = 16'd0;
            cur_tgt  = 11'd0;
            spd_tgt  = 15'd0;
            thr_stop = STOP_THR_RESET;
            thr_halt = HALT_THR_RESET;
            due_results.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_STOP_THR: thr_stop = cfg_data;
                    REG_HALT_THR: thr_halt = cfg_data;
                    default: ;
                endcase
            end

            // A result beat can never belong to a tick taken on the same edge
            if (result.valid && result.ready)
            begin
                got.sequencer_state     = result.sequencer_state;
                got.drive_mode          = result.drive_mode;
                got.current_reference   = result.current_reference;
                got.current_ramp_target = result.current_ramp_target;
                got.speed_ramp_target   = result.speed_ramp_target;
                got.speed_ramp_clear    = result.speed_ramp_clear;
                got.applied_direction   = result.applied_direction;
                if (due_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result beat with no tick outstanding", $time);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"%0t: result mismatch (expected/actual) state %0d/%0d",
                                      " mode %0d/%0d ref %0d/%0d cur_tgt %0d/%0d",
                                      " spd_tgt %0d/%0d clear %0b/%0b dir %0b/%0b"},
                                     $time,
                                     want.sequencer_state, got.sequencer_state,
                                     want.drive_mode, got.drive_mode,
                                     want.current_reference, got.current_reference,
                                     want.current_ramp_target, got.current_ramp_target,
                                     want.speed_ramp_target, got.speed_ramp_target,
                                     want.speed_ramp_clear, got.speed_ramp_clear,
                                     want.applied_direction, got.applied_direction);
                    end
                end
            end

            if (tick.valid && tick.ready)
            begin
                t.measured_speed    = tick.measured_speed;
                t.direction_request = tick.direction_request;
                t.torque_demand     = tick.torque_demand;
                t.auto_enable       = tick.auto_enable;
                t.speed_setpoint    = tick.speed_setpoint;
                t.ramped_current    = tick.ramped_current;
                t.speed_loop_output = tick.speed_loop_output;
                due_results.push_back(sequence_tick(t));
            end
        end
    end

endmodule

### dv/motor_drive_mode_sequencer_test.sv
// ----------------------------------------------------------------------------
// motor_drive_mode_sequencer_test
// Drives control ticks into the drive mode sequencer: a directed walk through
// every state, mode and edge value, then bursts of torque, speed, stop,
// reversal and noise ticks under several threshold settings and stall mixes.
// The checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module motor_drive_mode_sequencer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mdms_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef enum int
    {
        BURST_TORQUE,
        BURST_SPEED,
        BURST_STOP,
        BURST_REVERSE,
        BURST_NOISE
    } burst_kind_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  sink_ready = 1'b0;
    logic                  want_dir = 1'b0;
    int                    snd_idle_pct = 0;
    int                    rcv_idle_pct = 0;
    int                    mismatch_count;
    int                    results_due;

    mdms_tick_if   tick_ch ();
    mdms_result_if result_ch ();

    assign result_ch.ready = sink_ready;

    motor_drive_mode_sequencer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mdms_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .tick           (tick_ch),
        .result         (result_ch),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Stall the result side at random
    always @(posedge clk)
    begin
        sink_ready <= rst_n && ($urandom_range(99) >= rcv_idle_pct);
    end

    // Hard stop if the run hangs
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("FAIL");
        $finish;
    end

    // Field pickers biased toward edges and the thresholds' neighborhood
    function automatic logic signed [15:0] pick_speed(input bit slow);
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return 16'sh8000;
        if (r < 10)
            return 16'sh7fff;
        if (slow || r < 50)
            return 16'(int'($urandom_range(700)) - 350);
        return 16'($urandom);
    endfunction

    function automatic logic signed [15:0] pick_current();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return 16'sd0;
        if (r < 14)
            return 16'sh8000;
        if (r < 17)
            return 16'sh7fff;
        return 16'($urandom);
    endfunction

    function automatic logic [10:0] pick_torque();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return 11'd2047;
        if (r < 40)
            return 11'($urandom_range(20, 1));
        return 11'($urandom_range(2047, 1));
    endfunction

    function automatic logic [14:0] pick_setpoint();
        if ($urandom_range(9) == 0)
            return 15'd32767;
        return 15'($urandom_range(32767, 1));
    endfunction

    // Build one tick in the shape of the given burst
    function automatic tick_t make_tick(input burst_kind_t kind);
        tick_t t;
        t.measured_speed    = pick_speed(1'b0);
        t.direction_request = want_dir;
        t.torque_demand     = 11'($urandom);
        t.auto_enable       = 1'($urandom);
        t.speed_setpoint    = 15'($urandom);
        t.ramped_current    = pick_current();
        t.speed_loop_output = 16'($urandom);
        case (kind)
            BURST_TORQUE:
            begin
                t.torque_demand = ($urandom_range(3) == 0) ? 11'd0 : pick_torque();
            end
            BURST_SPEED:
            begin
                t.torque_demand  = ($urandom_range(9) == 0) ? pick_torque() : 11'd0;
                t.auto_enable    = ($urandom_range(7) != 0);
                t.speed_setpoint = ($urandom_range(4) == 0) ? 15'd0 : pick_setpoint();
            end
            BURST_STOP:
            begin
                t.measured_speed = pick_speed(1'b1);
                t.torque_demand  = 11'd0;
                t.speed_setpoint = ($urandom_range(1) == 0) ? 15'd0 : pick_setpoint();
                t.ramped_current = ($urandom_range(2) == 0) ? pick_current() : 16'sd0;
            end
            BURST_REVERSE:
            begin
                t.measured_speed = pick_speed($urandom_range(3) != 0);
                t.torque_demand  = ($urandom_range(3) == 0) ? pick_torque() : 11'd0;
            end
            default:
            begin
                t.measured_speed    = 16'($urandom);
                t.direction_request = 1'($urandom);
                t.ramped_current    = 16'($urandom);
            end
        endcase
        return t;
    endfunction

    // Offer one beat, with random idle cycles ahead of it
    task automatic send_tick(input tick_t t);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            tick_ch.valid <= 1'b0;
            @(posedge clk);
        end
        tick_ch.valid             <= 1'b1;
        tick_ch.measured_speed    <= t.measured_speed;
        tick_ch.direction_request <= t.direction_request;
        tick_ch.torque_demand     <= t.torque_demand;
        tick_ch.auto_enable       <= t.auto_enable;
        tick_ch.speed_setpoint    <= t.speed_setpoint;
        tick_ch.ramped_current    <= t.ramped_current;
        tick_ch.speed_loop_output <= t.speed_loop_output;
        @(posedge clk);
        while (!tick_ch.ready)
            @(posedge clk);
    endtask

    // Hold the tick side until every predicted result has come back
    task automatic wait_drained();
        tick_ch.valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
    endtask

    task automatic program_thresholds(input logic [14:0] stop_thr,
                                      input logic [14:0] halt_thr);
        cfg_we    <= 1'b1;
        cfg_index <= REG_STOP_THR;
        cfg_data  <= stop_thr;
        @(posedge clk);
        cfg_index <= REG_HALT_THR;
        cfg_data  <= halt_thr;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // One threshold setting and stall mix, fed as bursts of shaped ticks
    task automatic run_phase(input logic [14:0] stop_thr, input logic [14:0] halt_thr,
                             input int snd_pct, input int rcv_pct,
                             input int n_ticks, input bit pause_mid);
        int          sent;
        int          len;
        int          r;
        burst_kind_t kind;
        wait_drained();
        program_thresholds(stop_thr, halt_thr);
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        sent = 0;
        while (sent < n_ticks)
        begin
            r = $urandom_range(99);
            kind = (r < 25) ? BURST_TORQUE :
                   (r < 50) ? BURST_SPEED :
                   (r < 70) ? BURST_STOP :
                   (r < 85) ? BURST_REVERSE : BURST_NOISE;
            if (kind == BURST_REVERSE)
                want_dir = ~want_dir;
            len = $urandom_range(20, 6);
            for (int i = 0; i < len && sent < n_ticks; i++)
            begin
                send_tick(make_tick(kind));
                sent++;
                if (pause_mid && sent == n_ticks / 2)
                    wait_drained();
            end
        end
    endtask

    initial
    begin
        tick_ch.valid             <= 1'b0;
        tick_ch.measured_speed    <= '0;
        tick_ch.direction_request <= 1'b0;
        tick_ch.torque_demand     <= '0;
        tick_ch.auto_enable       <= 1'b0;
        tick_ch.speed_setpoint    <= '0;
        tick_ch.ramped_current    <= '0;
        tick_ch.speed_loop_output <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk with reset thresholds (stop 100, halt 200)
        snd_idle_pct = 25;
        rcv_idle_pct = 52;
        // init to start, then start into torque run at full scale
        send_tick(tick_t'{16'sd0, 1'b0, 11'd0, 1'b0, 15'd0, 16'sd0, 16'sd0});
        send_tick(tick_t'{16'sh7fff, 1'b0, 11'd2047, 1'b1, 15'd32767, 16'sh7fff,
                          16'sh7fff});
        // torque run with a live reference stays, then zero reference and slow
        send_tick(tick_t'{16'sh8000, 1'b0, 11'd5, 1'b0, 15'd0, 16'sd0, 16'sd0});
        send_tick(tick_t'{16'sd150, 1'b0, 11'd0, 1'b0, 15'd0, 16'sd0, 16'sd0});
        // reverse request: direction change, full-scale negative speed holds it
        send_tick(tick_t'{16'sd0, 1'b1, 11'd0, 1'b0, 15'd0, 16'sh8000, 16'sd0});
        send_tick(tick_t'{16'sh8000, 1'b1, 11'd0, 1'b0, 15'd0, 16'sd0, 16'sd0});
        send_tick(tick_t'{-16'sd99, 1'b1, 11'd0, 1'b0, 15'd0, 16'sd0, 16'sd0});
        // anticlockwise torque: negation of -32768 stays -32768
        send_tick(tick_t'{-16'sd500, 1'b1, 11'd1024, 1'b0, 15'd0, 16'sh8000, 16'sd0});
        send_tick(tick_t'{-16'sd500, 1'b1, 11'd1, 1'b0, 15'd0, 16'sh7fff, 16'sd0});
        // back to clockwise; speed at exactly the stop threshold is not stopped
        send_tick(tick_t'{16'sd100, 1'b0, 11'd0, 1'b0, 15'd0, 16'sd1, 16'sd0});
        send_tick(tick_t'{16'sd100, 1'b0, 11'd0, 1'b0, 15'd0, 16'sd0, 16'sd0});
        send_tick(tick_t'{16'sd0, 1'b0, 11'd0, 1'b1, 15'd32767, 16'sd0, 16'sd0});
        // enter speed run with ramp clear, then track setpoints
        send_tick(tick_t'{16'sd0, 1'b0, 11'd0, 1'b1, 15'd32767, 16'sd0, 16'sh8000});
        send_tick(tick_t'{16'sd5000, 1'b0, 11'd0, 1'b1, 15'd1, 16'sd0, 16'sh7fff});
        send_tick(tick_t'{16'sd5000, 1'b0, 11'd0, 1'b0, 15'd32767, 16'sd9, -16'sd7});
        send_tick(tick_t'{16'sd5000, 1'b0, 11'd2047, 1'b1, 15'd500, 16'sd7, 16'sd3});
        // torque run: nonzero held reference keeps it there once
        send_tick(tick_t'{16'sd0, 1'b0, 11'd0, 1'b0, 15'd0, 16'sd0, 16'sd0});
        send_tick(tick_t'{16'sd0, 1'b0, 11'd0, 1'b0, 15'd0, 16'sd0, 16'sd0});
        send_tick(tick_t'{16'sd0, 1'b0, 11'd0, 1'b1, 15'd100, 16'sd0, 16'sd11});
        send_tick(tick_t'{16'sd0, 1'b0, 11'd0, 1'b1, 15'd0, 16'sd0, 16'sd0});
        // speed run entered while turning fast, auto dropped but not stopped
        send_tick(tick_t'{16'sh8000, 1'b0, 11'd0, 1'b1, 15'd1, 16'sd0, 16'sd0});
        send_tick(tick_t'{16'sh8000, 1'b0, 11'd0, 1'b0, 15'd0, 16'sd0, 16'sd0});

        // Random bursts across threshold settings and stall mixes
        run_phase(15'd0, 15'd0, 25, 52, 110, 1'b0);
        run_phase(15'd32767, 15'd32767, 25, 52, 110, 1'b1);
        run_phase(15'($urandom), 15'($urandom), 52, 25, 110, 1'b0);
        run_phase(15'd300, 15'd600, 52, 25, 110, 1'b0);
        run_phase(STOP_THR_RESET, HALT_THR_RESET, 0, 0, 110, 1'b0);
        run_phase(15'($urandom_range(1000)), 15'($urandom_range(2000)), 0, 0, 100, 1'b0);

        wait_drained();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && results_due == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### files.f
+incdir+src
src/mdms_pkg.sv
src/mdms_if.sv
src/mdms_cfg_regs.sv
src/mdms_step.sv
src/motor_drive_mode_sequencer.sv
dv/mdms_checker.sv
dv/motor_drive_mode_sequencer_test.sv
